// ----- rtl/d2s_pkg.sv -----
// ----------------------------------------------------------------------------
// d2s_pkg: shared types and constants for the depth-to-space index map
// Index and dimension widths, register indexes, layout codes and the
// records that travel down the divider and multiply-add pipelines.
// ----------------------------------------------------------------------------
package d2s_pkg;

   localparam int INDEX_BITS     = 31;
   localparam int DIM_BITS       = 16;
   localparam int BS_BITS        = 7;
   localparam int DIV_BITS       = 2 * DIM_BITS;
   localparam int OW_BITS        = DIM_BITS + BS_BITS;
   localparam int DEPTH_BITS     = DIM_BITS + 2 * BS_BITS;
   localparam int SUB_BITS       = 2 * BS_BITS;
   localparam int SUBD_BITS      = SUB_BITS + DIM_BITS;
   localparam int TERMS          = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = DIM_BITS;

   typedef logic [INDEX_BITS-1:0] index_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_LAYOUT       = 3'd0,
      REG_BLOCK_SIZE   = 3'd1,
      REG_INPUT_HEIGHT = 3'd2,
      REG_INPUT_WIDTH  = 3'd3,
      REG_OUTPUT_DEPTH = 3'd4
   } reg_index_type;

   typedef enum logic {
      LAYOUT_CHANNELS_LAST  = 1'b0,
      LAYOUT_CHANNELS_FIRST = 1'b1
   } layout_type;

   // quotients and remainders collected along the divider chain
   typedef struct packed {
      index_type rem1;
      index_type rem2;
      index_type rem3;
      index_type quo3;
      index_type rem4;
      index_type quo4;
   } side_type;

   // Horner accumulator and the terms still to be added, next term first
   typedef struct packed {
      index_type                        acc;
      logic [TERMS-1:0][INDEX_BITS-1:0] addend;
   } hor_type;

endpackage

// ----- rtl/d2s_div.sv -----
// ----------------------------------------------------------------------------
// d2s_div: pipelined restoring divider
// One quotient bit per stage. The divisor must stay static while words are
// in flight (not enforced). A side record rides along with each word.
// ----------------------------------------------------------------------------
module d2s_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          up_valid,
   input  d2s_pkg::index_type            up_dvd,
   input  logic [d2s_pkg::DIV_BITS-1:0]  dvs,
   input  d2s_pkg::side_type             up_side,
   output logic                          dn_valid,
   output d2s_pkg::index_type            dn_quo,
   output d2s_pkg::index_type            dn_rem,
   output d2s_pkg::side_type             dn_side
);
   import d2s_pkg::*;

   localparam int STAGES = INDEX_BITS;

   logic                valid_ff [STAGES+1];
   logic                valid_in [STAGES+1];
   logic [DIV_BITS-1:0] rem_ff   [STAGES+1];
   logic [DIV_BITS-1:0] rem_in   [STAGES+1];
   index_type           dq_ff    [STAGES+1];
   index_type           dq_in    [STAGES+1];
   side_type            side_ff  [STAGES+1];
   side_type            side_in  [STAGES+1];

   assign valid_in[0] = up_valid;
   assign rem_in[0]   = '0;
   assign dq_in[0]    = up_dvd;
   assign side_in[0]  = up_side;

   // dividend bits shift out of the top of dq while quotient bits enter below
   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic [DIV_BITS:0] trial;
      logic              fits;
      assign trial         = {rem_ff[i], dq_ff[i][INDEX_BITS-1]};
      assign fits          = trial >= {1'b0, dvs};
      assign valid_in[i+1] = valid_ff[i];
      assign rem_in[i+1]   = fits ? DIV_BITS'(trial - {1'b0, dvs}) : trial[DIV_BITS-1:0];
      assign dq_in[i+1]    = {dq_ff[i][INDEX_BITS-2:0], fits};
      assign side_in[i+1]  = side_ff[i];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= STAGES; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= valid_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i <= STAGES; i++) begin
            rem_ff[i]  <= rem_in[i];
            dq_ff[i]   <= dq_in[i];
            side_ff[i] <= side_in[i];
         end
      end
   end

   assign dn_valid = valid_ff[STAGES];
   assign dn_quo   = dq_ff[STAGES];
   // remainder never exceeds the dividend, so it fits an index
   assign dn_rem   = INDEX_BITS'(rem_ff[STAGES]);
   assign dn_side  = side_ff[STAGES];

endmodule

// ----- rtl/d2s_prep.sv -----
// ----------------------------------------------------------------------------
// d2s_prep: term selection for the Horner chain
// Picks the accumulator seed and addends for the active layout and builds
// the source depth offset of the channels-last mapping over three stages.
// ----------------------------------------------------------------------------
module d2s_prep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  d2s_pkg::layout_type           layout,
   input  logic [d2s_pkg::BS_BITS-1:0]   bs,
   input  logic [d2s_pkg::DIM_BITS-1:0]  od,
   input  logic                          up_valid,
   input  d2s_pkg::index_type            up_quo,
   input  d2s_pkg::index_type            up_rem,
   input  d2s_pkg::side_type             up_side,
   output logic                          dn_valid,
   output d2s_pkg::hor_type              dn_hor
);
   import d2s_pkg::*;

   logic                 valid1_ff, valid2_ff, valid3_ff;
   hor_type              hor1_ff, hor1_in;
   hor_type              hor2_ff;
   hor_type              hor3_ff, hor3_in;
   logic [SUB_BITS-1:0]  hmbs_ff, hmbs_in;
   logic [SUBD_BITS-1:0] prod2_ff, prod2_in;
   index_type            d1_ff, d2_ff;

   always_comb begin
      hor1_in = '0;
      if (layout == LAYOUT_CHANNELS_FIRST) begin
         hor1_in.acc       = up_side.quo4;
         hor1_in.addend[0] = up_side.rem2;
         hor1_in.addend[1] = up_side.rem4;
         hor1_in.addend[2] = up_side.rem1;
         hor1_in.addend[3] = up_side.rem3;
      end else begin
         // depth term joins at stage three, last term stays zero
         hor1_in.acc       = up_side.quo3;
         hor1_in.addend[0] = up_side.quo4;
         hor1_in.addend[1] = up_quo;
      end
   end

   // (h % bs) * bs + (w % bs), both remainders below bs
   assign hmbs_in  = SUB_BITS'(BS_BITS'(up_side.rem4)) * SUB_BITS'(bs)
                     + SUB_BITS'(BS_BITS'(up_rem));
   assign prod2_in = SUBD_BITS'(hmbs_ff) * SUBD_BITS'(od);

   always_comb begin
      hor3_in = hor2_ff;
      if (layout == LAYOUT_CHANNELS_LAST) begin
         hor3_in.addend[2] = INDEX_BITS'(prod2_ff) + d2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= up_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hor1_ff  <= hor1_in;
         hmbs_ff  <= hmbs_in;
         d1_ff    <= up_side.rem1;
         hor2_ff  <= hor1_ff;
         prod2_ff <= prod2_in;
         d2_ff    <= d1_ff;
         hor3_ff  <= hor3_in;
      end
   end

   assign dn_valid = valid3_ff;
   assign dn_hor   = hor3_ff;

endmodule

// ----- rtl/d2s_mac.sv -----
// ----------------------------------------------------------------------------
// d2s_mac: one Horner step, acc = acc * k + next addend
// Multiply in the first stage, add and shift the addend list in the second.
// All arithmetic wraps at the index width.
// ----------------------------------------------------------------------------
module d2s_mac (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  d2s_pkg::index_type  k,
   input  logic                up_valid,
   input  d2s_pkg::hor_type    up_hor,
   output logic                dn_valid,
   output d2s_pkg::hor_type    dn_hor
);
   import d2s_pkg::*;

   logic      valid_a_ff, valid_b_ff;
   index_type prod_ff, prod_in;
   hor_type   hor_a_ff;
   hor_type   hor_b_ff, hor_b_in;

   assign prod_in = INDEX_BITS'(up_hor.acc * k);

   always_comb begin
      hor_b_in     = hor_a_ff;
      hor_b_in.acc = prod_ff + hor_a_ff.addend[0];
      for (int j = 0; j < TERMS - 1; j++) begin
         hor_b_in.addend[j] = hor_a_ff.addend[j+1];
      end
      hor_b_in.addend[TERMS-1] = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= up_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff  <= prod_in;
         hor_a_ff <= up_hor;
         hor_b_ff <= hor_b_in;
      end
   end

   assign dn_valid = valid_b_ff;
   assign dn_hor   = hor_b_ff;

endmodule

// ----- rtl/depth_to_space_index_map.sv -----
// ----------------------------------------------------------------------------
// depth_to_space_index_map: address generator for depth-to-space
// Maps one flattened element index to its paired index per word.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: req_valid / req_stall / req_linear_index. A word is taken at
//    a clock edge with req_valid high and req_stall low.
//  - rsp channel: rsp_valid / rsp_stall / rsp_mapped_index, one result word
//    per request word, in order.
//  - csr channel: csr_valid / csr_ready / csr_index / csr_data. csr_ready is
//    always high; write registers only while no words are in flight.
//  - Throughput: one word per cycle, sustained while req_stall is low.
//  - Pipeline: a word passes 172 registers on its way to rsp_valid, the
//    first loaded at the accepting edge: five chained restoring
//    dividers (an input register and 31 quotient-bit stages each), three
//    term-selection stages, four two-stage multiply-add steps and the output
//    register.
//  - Derived products of the dimensions are registered after a write and
//    settle well before a word reaches the dividers that use them.
//  - Reset: registers return to channels-last, block size 2, all dimensions 1;
//    the pipeline empties.
//  - Receiver stall: the output register plus one skid word absorb it; once
//    the skid word is full, req_stall rises and the whole pipeline holds.
// ----------------------------------------------------------------------------
module depth_to_space_index_map (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [d2s_pkg::INDEX_BITS-1:0]      req_linear_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [d2s_pkg::INDEX_BITS-1:0]      rsp_mapped_index,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [d2s_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [d2s_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import d2s_pkg::*;

   // configuration
   layout_type            layout_ff;
   logic [BS_BITS-1:0]    block_size_ff;
   logic [DIM_BITS-1:0]   input_height_ff, input_width_ff, output_depth_ff;
   logic [BS_BITS-1:0]    bs_eff;
   logic [DIM_BITS-1:0]   ih_eff, iw_eff, od_eff;
   logic [OW_BITS-1:0]    ow_ff, ow_in, oh_ff, oh_in, odbs_ff, odbs_in;
   logic [DIV_BITS-1:0]   odih_ff, odih_in;
   logic [DEPTH_BITS-1:0] iddepth_ff, iddepth_in;
   logic                  layout_cf;

   // pipeline
   logic                  advance;
   logic [DIV_BITS-1:0]   dvs1, dvs2, dvs3, dvs_bs;
   index_type             k1, k2, k3, k4;
   logic                  dv1_valid, dv2_valid, dv3_valid, dv4_valid, dv5_valid;
   index_type             dv1_quo, dv2_quo, dv3_quo, dv4_quo, dv5_quo;
   index_type             dv1_rem, dv2_rem, dv3_rem, dv4_rem, dv5_rem;
   side_type              dv1_side, dv2_side, dv3_side, dv4_side, dv5_side;
   side_type              side_a, side_b, side_c, side_d;
   index_type             dvd4;
   logic                  pr_valid, m1_valid, m2_valid, m3_valid, pipe_valid;
   hor_type               pr_hor, m1_hor, m2_hor, m3_hor, m4_hor;
   index_type             pipe_data;

   // output buffer
   logic                  rsp_valid_ff, rsp_valid_in;
   index_type             rsp_data_ff, rsp_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   index_type             skid_data_ff, skid_data_in;
   logic                  out_take;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff       <= LAYOUT_CHANNELS_LAST;
         block_size_ff   <= BS_BITS'(2);
         input_height_ff <= DIM_BITS'(1);
         input_width_ff  <= DIM_BITS'(1);
         output_depth_ff <= DIM_BITS'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_LAYOUT:       layout_ff       <= layout_type'(csr_data[0]);
            REG_BLOCK_SIZE:   block_size_ff   <= csr_data[BS_BITS-1:0];
            REG_INPUT_HEIGHT: input_height_ff <= csr_data[DIM_BITS-1:0];
            REG_INPUT_WIDTH:  input_width_ff  <= csr_data[DIM_BITS-1:0];
            REG_OUTPUT_DEPTH: output_depth_ff <= csr_data[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   // a zero size acts as one
   assign bs_eff = (block_size_ff == '0) ? BS_BITS'(1) : block_size_ff;
   assign ih_eff = (input_height_ff == '0) ? DIM_BITS'(1) : input_height_ff;
   assign iw_eff = (input_width_ff == '0) ? DIM_BITS'(1) : input_width_ff;
   assign od_eff = (output_depth_ff == '0) ? DIM_BITS'(1) : output_depth_ff;

   assign layout_cf  = (layout_ff == LAYOUT_CHANNELS_FIRST);
   assign ow_in      = OW_BITS'(iw_eff) * OW_BITS'(bs_eff);
   assign oh_in      = OW_BITS'(ih_eff) * OW_BITS'(bs_eff);
   assign odbs_in    = OW_BITS'(od_eff) * OW_BITS'(bs_eff);
   assign odih_in    = DIV_BITS'(od_eff) * DIV_BITS'(ih_eff);
   assign iddepth_in = DEPTH_BITS'(odbs_ff) * DEPTH_BITS'(bs_eff);

   always_ff @(posedge clock) begin
      ow_ff      <= ow_in;
      oh_ff      <= oh_in;
      odbs_ff    <= odbs_in;
      odih_ff    <= odih_in;
      iddepth_ff <= iddepth_in;
   end

   assign dvs1   = layout_cf ? DIV_BITS'(iw_eff) : DIV_BITS'(od_eff);
   assign dvs2   = layout_cf ? odih_ff : DIV_BITS'(ow_ff);
   assign dvs3   = layout_cf ? DIV_BITS'(bs_eff) : DIV_BITS'(oh_ff);
   assign dvs_bs = DIV_BITS'(bs_eff);

   assign k1 = layout_cf ? INDEX_BITS'(odih_ff) : INDEX_BITS'(ih_eff);
   assign k2 = layout_cf ? INDEX_BITS'(bs_eff) : INDEX_BITS'(iw_eff);
   assign k3 = layout_cf ? INDEX_BITS'(iw_eff) : INDEX_BITS'(iddepth_ff);
   assign k4 = layout_cf ? INDEX_BITS'(bs_eff) : INDEX_BITS'(1);

   // ---------------------------------------------------------- divider chain
   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_comb begin
      side_a      = dv1_side;
      side_a.rem1 = dv1_rem;
      side_b      = dv2_side;
      side_b.rem2 = dv2_rem;
      side_c      = dv3_side;
      side_c.rem3 = dv3_rem;
      side_c.quo3 = dv3_quo;
      side_d      = dv4_side;
      side_d.rem4 = dv4_rem;
      side_d.quo4 = dv4_quo;
   end

   // channels-last splits the row coordinate, channels-first the batch word
   assign dvd4 = layout_cf ? dv3_quo : dv3_rem;

   d2s_div u_div1 (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .up_valid (req_valid),
      .up_dvd   (req_linear_index),
      .dvs      (dvs1),
      .up_side  ('0),
      .dn_valid (dv1_valid),
      .dn_quo   (dv1_quo),
      .dn_rem   (dv1_rem),
      .dn_side  (dv1_side)
   );

   d2s_div u_div2 (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .up_valid (dv1_valid),
      .up_dvd   (dv1_quo),
      .dvs      (dvs2),
      .up_side  (side_a),
      .dn_valid (dv2_valid),
      .dn_quo   (dv2_quo),
      .dn_rem   (dv2_rem),
      .dn_side  (dv2_side)
   );

   d2s_div u_div3 (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .up_valid (dv2_valid),
      .up_dvd   (dv2_quo),
      .dvs      (dvs3),
      .up_side  (side_b),
      .dn_valid (dv3_valid),
      .dn_quo   (dv3_quo),
      .dn_rem   (dv3_rem),
      .dn_side  (dv3_side)
   );

   d2s_div u_div4 (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .up_valid (dv3_valid),
      .up_dvd   (dvd4),
      .dvs      (dvs_bs),
      .up_side  (side_c),
      .dn_valid (dv4_valid),
      .dn_quo   (dv4_quo),
      .dn_rem   (dv4_rem),
      .dn_side  (dv4_side)
   );

   // column split by block size; unused in channels-first
   d2s_div u_div5 (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .up_valid (dv4_valid),
      .up_dvd   (dv4_side.rem2),
      .dvs      (dvs_bs),
      .up_side  (side_d),
      .dn_valid (dv5_valid),
      .dn_quo   (dv5_quo),
      .dn_rem   (dv5_rem),
      .dn_side  (dv5_side)
   );

   // ------------------------------------------------------- multiply-add chain
   d2s_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .layout   (layout_ff),
      .bs       (bs_eff),
      .od       (od_eff),
      .up_valid (dv5_valid),
      .up_quo   (dv5_quo),
      .up_rem   (dv5_rem),
      .up_side  (dv5_side),
      .dn_valid (pr_valid),
      .dn_hor   (pr_hor)
   );

   d2s_mac u_mac1 (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .k        (k1),
      .up_valid (pr_valid),
      .up_hor   (pr_hor),
      .dn_valid (m1_valid),
      .dn_hor   (m1_hor)
   );

   d2s_mac u_mac2 (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .k        (k2),
      .up_valid (m1_valid),
      .up_hor   (m1_hor),
      .dn_valid (m2_valid),
      .dn_hor   (m2_hor)
   );

   d2s_mac u_mac3 (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .k        (k3),
      .up_valid (m2_valid),
      .up_hor   (m2_hor),
      .dn_valid (m3_valid),
      .dn_hor   (m3_hor)
   );

   d2s_mac u_mac4 (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .k        (k4),
      .up_valid (m3_valid),
      .up_hor   (m3_hor),
      .dn_valid (pipe_valid),
      .dn_hor   (m4_hor)
   );

   assign pipe_data = m4_hor.acc;

   // ----------------------------------------------------------- output buffer
   assign out_take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // pipeline is frozen; drain the skid word once the output moves
         if (out_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!rsp_valid_ff || out_take) begin
         rsp_valid_in = pipe_valid;
         rsp_data_in  = pipe_data;
      end else if (pipe_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = pipe_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mapped_index = rsp_data_ff;

   // -------------------------------------------------------------- assertions
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word held while output register is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_stall))
      else $error("skid word filled without a receiver stall");

   a_pipe_hold: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pipe_valid |=> pipe_valid && $stable(pipe_data))
      else $error("pipeline word moved while the skid word was full");

endmodule

// ----- bench/index_map_checker.sv -----
// ----------------------------------------------------------------------------
// index_map_checker: result predictor and comparator for the index map
// Tracks register writes, predicts the paired index of every accepted request
// word, and compares each accepted response word in order against it.
// ----------------------------------------------------------------------------
module index_map_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  d2s_pkg::index_type                  req_linear_index,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  d2s_pkg::index_type                  rsp_mapped_index,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [d2s_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [d2s_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output int                                  outstanding,
   output int                                  mismatches,
   output int                                  checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import d2s_pkg::*;

   layout_type            cfg_layout = LAYOUT_CHANNELS_LAST;
   logic [BS_BITS-1:0]    cfg_block  = 7'd2;
   logic [DIM_BITS-1:0]   cfg_height = 16'd1;
   logic [DIM_BITS-1:0]   cfg_width  = 16'd1;
   logic [DIM_BITS-1:0]   cfg_depth  = 16'd1;
   index_type             due_indexes[$];
   int                    fail_tally    = 0;
   int                    checked_tally = 0;

   // Wide unsigned arithmetic wraps like the block's; only the low bits survive.
   function automatic index_type paired_index(
      input index_type           idx,
      input layout_type          lay,
      input logic [BS_BITS-1:0]  bs_reg,
      input logic [DIM_BITS-1:0] ih_reg,
      input logic [DIM_BITS-1:0] iw_reg,
      input logic [DIM_BITS-1:0] od_reg
   );
      bit [63:0] x, bs, ih, iw, od, q, d, w, h, b, ix, lo, bx, by, n, res;
      x  = 64'(idx);
      bs = (bs_reg == '0) ? 64'd1 : 64'(bs_reg);
      ih = (ih_reg == '0) ? 64'd1 : 64'(ih_reg);
      iw = (iw_reg == '0) ? 64'd1 : 64'(iw_reg);
      od = (od_reg == '0) ? 64'd1 : 64'(od_reg);
      if (lay == LAYOUT_CHANNELS_LAST) begin
         // destination (b, h, w, d) back to source (b, h/bs, w/bs, depth)
         d   = x % od;
         q   = x / od;
         w   = q % (iw * bs);
         q   = q / (iw * bs);
         h   = q % (ih * bs);
         b   = q / (ih * bs);
         res = d + ((h % bs) * bs + w % bs) * od
               + od * bs * bs * (w / bs + iw * (h / bs + ih * b));
      end else begin
         // source (n, bY, bX, oC, iY, iX) forward to (n, oC, iY, bY, iX, bX)
         q   = x / iw;
         ix  = x % iw;
         lo  = q % (od * ih);
         q   = q / (od * ih);
         bx  = q % bs;
         q   = q / bs;
         by  = q % bs;
         n   = q / bs;
         res = bx + bs * (ix + iw * (by + bs * (lo + n * od * ih)));
      end
      return res[INDEX_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      fail_tally++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   always @(posedge clock) begin
      index_type want;
      if (reset) begin
         cfg_layout = LAYOUT_CHANNELS_LAST;
         cfg_block  = 7'd2;
         cfg_height = 16'd1;
         cfg_width  = 16'd1;
         cfg_depth  = 16'd1;
         due_indexes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_indexes.size() == 0) begin
               report_mismatch($sformatf("response word %0h with none pending",
                                         rsp_mapped_index));
            end else begin
               want = due_indexes.pop_front();
               checked_tally++;
               if (rsp_mapped_index !== want)
                  report_mismatch($sformatf("mapped_index %0h, predicted %0h",
                                            rsp_mapped_index, want));
            end
         end
         if (req_valid && !req_stall)
            due_indexes.push_back(paired_index(req_linear_index, cfg_layout, cfg_block,
                                               cfg_height, cfg_width, cfg_depth));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_LAYOUT:       cfg_layout = layout_type'(csr_data[0]);
               REG_BLOCK_SIZE:   cfg_block  = csr_data[BS_BITS-1:0];
               REG_INPUT_HEIGHT: cfg_height = csr_data[DIM_BITS-1:0];
               REG_INPUT_WIDTH:  cfg_width  = csr_data[DIM_BITS-1:0];
               REG_OUTPUT_DEPTH: cfg_depth  = csr_data[DIM_BITS-1:0];
               default: ;
            endcase
         end
      end
      outstanding <= due_indexes.size();
      mismatches  <= fail_tally;
      checked     <= checked_tally;
   end

endmodule

// ----- bench/depth_to_space_index_map_tb.sv -----
// ----------------------------------------------------------------------------
// depth_to_space_index_map_tb: stimulus and verdict for the index map
// Walks the block through reset values and a series of register settings in
// both layouts, with random idle cycles on both channels and a long receiver
// hold-off that backs the pipeline up into the request channel.
// ----------------------------------------------------------------------------
module depth_to_space_index_map_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import d2s_pkg::*;

   localparam int        CYCLE_LIMIT = 200000;
   localparam int        HOLD_CYCLES = 400;
   localparam int        DRAIN_CYCLES = 200;
   localparam index_type INDEX_MAX = '1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FIRST_UNUSED = REG_OUTPUT_DEPTH + 3'd1;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   index_type                   req_linear_index = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   index_type                   rsp_mapped_index;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [CSR_DATA_BITS-1:0]    csr_data = '0;

   int        outstanding;
   int        mismatches;
   int        checked;
   int        cycle_count = 0;
   int        settings_used = 1;
   bit [63:0] cur_span = 64'd4;
   logic      calm = 1'b0;
   logic      hold_request = 1'b0;

   depth_to_space_index_map dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_linear_index (req_linear_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mapped_index (rsp_mapped_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   index_map_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_linear_index (req_linear_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mapped_index (rsp_mapped_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .outstanding      (outstanding),
      .mismatches       (mismatches),
      .checked          (checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly indexes inside a few batches of the tensor, the rest anywhere.
   function automatic index_type pick_index(input bit [63:0] span);
      bit [63:0] reach;
      int unsigned roll;
      reach = span * 4;
      if (reach > 64'h8000_0000 || reach == 0) reach = 64'h8000_0000;
      roll = $urandom_range(9);
      if (roll < 6) return index_type'($urandom_range(32'(reach - 1)));
      else if (roll == 9) return INDEX_MAX - index_type'($urandom_range(255));
      else return index_type'($urandom);
   endfunction

   task automatic push_index(input index_type value);
      int idle_cycles;
      idle_cycles = 0;
      while (!calm && $urandom_range(99) < 23) idle_cycles++;
      if (idle_cycles > 0) begin
         req_valid <= 1'b0;
         repeat (idle_cycles) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_linear_index <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic push_random(input int count);
      for (int k = 0; k < count; k++) push_index(pick_index(cur_span));
   endtask

   // Drop valid and hold until every predicted word has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input layout_type lay, input logic [BS_BITS-1:0] bs,
                            input logic [DIM_BITS-1:0] ih, input logic [DIM_BITS-1:0] iw,
                            input logic [DIM_BITS-1:0] od, input bit with_unused);
      bit [63:0] eb, eh, ew, ed;
      wait_idle();
      // junk in the upper data bits must be ignored
      write_reg(REG_LAYOUT, {15'($urandom), 1'(lay)});
      write_reg(REG_BLOCK_SIZE, {9'($urandom), bs});
      write_reg(REG_INPUT_HEIGHT, ih);
      write_reg(REG_INPUT_WIDTH, iw);
      write_reg(REG_OUTPUT_DEPTH, od);
      if (with_unused)
         for (int k = REG_FIRST_UNUSED; k < 2 ** CSR_INDEX_BITS; k++)
            write_reg(CSR_INDEX_BITS'(k), '1);
      csr_valid <= 1'b0;
      eb = (bs == '0) ? 64'd1 : 64'(bs);
      eh = (ih == '0) ? 64'd1 : 64'(ih);
      ew = (iw == '0) ? 64'd1 : 64'(iw);
      ed = (od == '0) ? 64'd1 : 64'(od);
      cur_span = eh * ew * ed * eb * eb;
      settings_used++;
   endtask

   task automatic edge_phase(input layout_type lay, input logic [BS_BITS-1:0] bs,
                             input logic [DIM_BITS-1:0] ih, input logic [DIM_BITS-1:0] iw,
                             input logic [DIM_BITS-1:0] od);
      configure(lay, bs, ih, iw, od, 1'b0);
      push_index('0);
      push_index(INDEX_MAX);
      push_random(30);
   endtask

   // Receiver: random stalls, or one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request <= 1'b0;
            rsp_stall    <= 1'b1;
            for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 23);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset values: block size 2, unit dimensions, channels-last
      push_index('0);
      push_index(index_type'(1));
      push_index(index_type'(2));
      push_index(index_type'(3));
      push_index(index_type'(5));
      push_index(index_type'(7));
      push_index(31'h2AAA_AAAA);
      push_index(31'h5555_5555);
      push_index(31'h4000_0000);
      push_index(INDEX_MAX);

      configure(LAYOUT_CHANNELS_LAST, 7'd3, 16'd4, 16'd5, 16'd3, 1'b1);
      push_random(60);
      configure(LAYOUT_CHANNELS_FIRST, 7'd2, 16'd3, 16'd7, 16'd2, 1'b0);
      push_random(60);

      edge_phase(LAYOUT_CHANNELS_LAST, 7'd64, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      edge_phase(LAYOUT_CHANNELS_FIRST, 7'd64, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      edge_phase(LAYOUT_CHANNELS_LAST, 7'd0, 16'd0, 16'd0, 16'd0);
      edge_phase(LAYOUT_CHANNELS_FIRST, 7'd1, 16'd0, 16'd0, 16'd0);
      edge_phase(LAYOUT_CHANNELS_LAST, 7'd127, 16'd1, 16'd2, 16'd1);
      edge_phase(LAYOUT_CHANNELS_FIRST, 7'd127, 16'd2, 16'd1, 16'd3);

      for (int p = 0; p < 4; p++) begin
         if (p < 3)
            configure(layout_type'($urandom_range(1)), 7'($urandom_range(2, 8)),
                      16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                      16'($urandom_range(1, 12)), 1'b0);
         else
            configure(layout_type'($urandom_range(1)), 7'($urandom_range(2, 64)),
                      16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
                      16'($urandom_range(1, 300)), 1'b0);
         push_random(40);
      end

      // back the pipeline up: no idling, receiver holds off for a long stretch
      configure(layout_type'($urandom_range(1)), 7'($urandom_range(2, 6)),
                16'($urandom_range(1, 9)), 16'($urandom_range(1, 9)),
                16'($urandom_range(1, 9)), 1'b0);
      calm         <= 1'b1;
      hold_request <= 1'b1;
      push_random(250);
      calm <= 1'b0;

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Mapped %0d indexes under %0d register settings, both layouts,",
               checked, settings_used);
      $display("%s %0d-cycle response hold-off.",
               "zero/unit/oversized block sizes, zero and full-width dimensions, a",
               HOLD_CYCLES);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/d2s_pkg.sv
rtl/d2s_div.sv
rtl/d2s_prep.sv
rtl/d2s_mac.sv
rtl/depth_to_space_index_map.sv
bench/index_map_checker.sv
bench/depth_to_space_index_map_tb.sv
